// File: hw/rtl/smt_pkg.sv
package smt_pkg;

    // default table depth
    localparam int CAPACITY_DEF = 64;

    // payload widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // one stored pair, as it sits in the table memory
    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

// File: hw/rtl/smt_if.sv
// request channel: one operation per transaction
interface smt_req_if;
    logic                               valid;
    logic                               ready;
    logic [smt_pkg::KIND_W-1:0]         kind;
    logic signed [smt_pkg::KEY_W-1:0]   key;
    logic signed [smt_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

// response channel: one or more results per transaction, last marks the final one
interface smt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [smt_pkg::STATUS_W-1:0]       status;
    logic signed [smt_pkg::VALUE_W-1:0] found_value;
    logic                               last;
    logic [smt_pkg::TOTAL_W-1:0]        entry_total;

    modport source (output valid, output status, output found_value, output last,
                    output entry_total, input ready);
    modport sink   (input valid, input status, input found_value, input last,
                    input entry_total, output ready);
endinterface

// configuration write channel: order register
interface smt_cfg_if;
    logic valid;
    logic ready;
    logic order_descending;

    modport source (output valid, output order_descending, input ready);
    modport sink   (input valid, input order_descending, output ready);
endinterface

// File: hw/rtl/smt_ram.sv
module smt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sorted_multimap_table_unit.sv
// sorted key/value table in one memory, walked from the front one entry per cycle
// except while a search holds a further match and the result output is still full
// output backpressure stalls a search and the final result; the next request is
// taken in the cycle after the final result loads
// reset empties the table and selects ascending order at once
module sorted_multimap_table_unit #(
    parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    smt_req_if.sink   req,
    smt_rsp_if.source rsp,
    smt_cfg_if.sink   cfg
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = $bits(smt_pkg::entry_t);
    localparam int TW = smt_pkg::TOTAL_W;
    localparam int SW = smt_pkg::STATUS_W;
    localparam int VW = smt_pkg::VALUE_W;
    localparam int KW = smt_pkg::KIND_W;
    localparam int YW = smt_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT_INS,
        S_SHIFT_REM,
        S_PUT,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [KW-1:0]         kind_reg, kind_next;
    logic signed [YW-1:0]  key_reg, key_next;
    logic signed [VW-1:0]  value_reg, value_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  order_reg, order_next;
    logic [SW-1:0]         fin_reg, fin_next;
    logic                  held_valid_reg, held_valid_next;
    logic signed [VW-1:0]  held_value_reg, held_value_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SW-1:0]         out_status_reg, out_status_next;
    logic signed [VW-1:0]  out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;
    logic [CW-1:0]         out_total_reg, out_total_next;

    // table memory signals
    logic                  ram_we;
    logic [CW-1:0]         wr_idx;
    logic [CW-1:0]         rd_idx;
    smt_pkg::entry_t       ram_wdata;
    logic [EW-1:0]         ram_rdata;
    smt_pkg::entry_t       q;

    logic                  ord;
    logic                  key_eq;
    logic                  pair_eq;
    logic                  last_entry;
    logic                  out_free;
    logic                  stall;

    smt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // entry under the walk and its comparisons
    assign q          = smt_pkg::entry_t'(ram_rdata);
    assign ord        = order_reg ? (q.key >= key_reg) : (q.key <= key_reg);
    assign key_eq     = (q.key == key_reg);
    assign pair_eq    = key_eq && (q.value == value_reg);
    assign last_entry = (CW'(idx_reg + CW'(1)) == cnt_reg);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign stall      = ord && key_eq && held_valid_reg && !out_free;

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        order_next      = order_reg;
        fin_next        = fin_reg;
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_total_next  = out_total_reg;
        rd_idx          = '0;
        ram_we          = 1'b0;
        wr_idx          = idx_reg;
        ram_wdata       = q;

        if (cfg.valid)
        begin
            order_next = cfg.order_descending;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next       = req.kind;
                    key_next        = req.key;
                    value_next      = req.value;
                    idx_next        = '0;
                    held_valid_next = 1'b0;
                    case (req.kind)
                        smt_pkg::KIND_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                fin_next   = smt_pkg::ST_FULL;
                                state_next = S_FINISH;
                            end
                            else if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        smt_pkg::KIND_SEARCH, smt_pkg::KIND_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_next   = smt_pkg::ST_MISS;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            fin_next   = smt_pkg::ST_MISS;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // default: step to the next entry
                rd_idx   = CW'(idx_reg + CW'(1));
                idx_next = CW'(idx_reg + CW'(1));
                case (kind_reg)
                    smt_pkg::KIND_INSERT:
                    begin
                        if (!ord)
                        begin
                            pos_next   = idx_reg;
                            rd_idx     = CW'(cnt_reg - CW'(1));
                            idx_next   = cnt_reg;
                            state_next = S_SHIFT_INS;
                        end
                        else if (last_entry)
                        begin
                            pos_next   = cnt_reg;
                            state_next = S_PUT;
                        end
                    end
                    smt_pkg::KIND_SEARCH:
                    begin
                        if (stall)
                        begin
                            rd_idx   = idx_reg;
                            idx_next = idx_reg;
                        end
                        else
                        begin
                            // keep one match back so the final one can carry last
                            if (ord && key_eq)
                            begin
                                if (held_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = smt_pkg::ST_OK;
                                    out_value_next  = held_value_reg;
                                    out_last_next   = 1'b0;
                                    out_total_next  = cnt_reg;
                                end
                                held_valid_next = 1'b1;
                                held_value_next = q.value;
                            end
                            if (!ord || last_entry)
                            begin
                                state_next = S_FINISH;
                            end
                        end
                    end
                    smt_pkg::KIND_REMOVE:
                    begin
                        if (ord && pair_eq)
                        begin
                            if (last_entry)
                            begin
                                cnt_next   = CW'(cnt_reg - CW'(1));
                                fin_next   = smt_pkg::ST_OK;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                idx_next   = idx_reg;
                                state_next = S_SHIFT_REM;
                            end
                        end
                        else if (!ord || last_entry)
                        begin
                            fin_next   = smt_pkg::ST_MISS;
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        fin_next   = smt_pkg::ST_MISS;
                        state_next = S_FINISH;
                    end
                endcase
            end

            // move entry idx-1 to idx, walking down toward the insert slot
            S_SHIFT_INS:
            begin
                ram_we = 1'b1;
                if (CW'(idx_reg - CW'(1)) == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_idx   = CW'(idx_reg - CW'(2));
                    idx_next = CW'(idx_reg - CW'(1));
                end
            end

            // move entry idx+1 to idx, closing the gap of the removed pair
            S_SHIFT_REM:
            begin
                ram_we = 1'b1;
                if (CW'(idx_reg + CW'(2)) == cnt_reg)
                begin
                    cnt_next   = CW'(cnt_reg - CW'(1));
                    fin_next   = smt_pkg::ST_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_idx   = CW'(idx_reg + CW'(2));
                    idx_next = CW'(idx_reg + CW'(1));
                end
            end

            S_PUT:
            begin
                ram_we          = 1'b1;
                wr_idx          = pos_reg;
                ram_wdata.key   = key_reg;
                ram_wdata.value = value_reg;
                cnt_next        = CW'(cnt_reg + CW'(1));
                fin_next        = smt_pkg::ST_OK;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_total_next = cnt_reg;
                    if (kind_reg == smt_pkg::KIND_SEARCH)
                    begin
                        out_status_next = held_valid_reg ? smt_pkg::ST_OK : smt_pkg::ST_MISS;
                        out_value_next  = held_valid_reg ? held_value_reg : '0;
                    end
                    else
                    begin
                        out_status_next = fin_reg;
                        out_value_next  = '0;
                    end
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            key_reg        <= '0;
            value_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            order_reg      <= 1'b0;
            fin_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_value_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_total_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            order_reg      <= order_next;
            fin_reg        <= fin_next;
            held_valid_reg <= held_valid_next;
            held_value_reg <= held_value_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
            out_total_reg  <= out_total_next;
        end
    end

    // channel outputs
    assign req.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_value_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.entry_total = TW'(out_total_reg);

`ifndef ASSERT_OFF
    // entry count stays within the table
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // entry count moves by at most one per cycle
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == CW'($past(cnt_reg) + CW'(1)) ||
             cnt_reg == CW'($past(cnt_reg) - CW'(1))))
        else $error("entry count jumped");

    // table writes stay inside the occupied region plus the insert slot
    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (wr_idx <= cnt_reg && wr_idx < CW'(CAPACITY)))
        else $error("table write outside occupied region");

    // a held match only exists during a search
    a_held_search: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (kind_reg == smt_pkg::KIND_SEARCH))
        else $error("held match outside a search");
`endif

endmodule

// File: tb/sorted_multimap_table_unit_test.sv
module sorted_multimap_table_unit_test;

    localparam int TABLE_DEPTH = smt_pkg::CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 600000;

    localparam int KIND_W   = smt_pkg::KIND_W;
    localparam int KEY_W    = smt_pkg::KEY_W;
    localparam int VALUE_W  = smt_pkg::VALUE_W;
    localparam int STATUS_W = smt_pkg::STATUS_W;
    localparam int TOTAL_W  = smt_pkg::TOTAL_W;

    // the one operation code the package leaves unnamed
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } table_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] found_value;
        logic                      last;
        logic [TOTAL_W-1:0]        entry_total;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    smt_req_if req();
    smt_rsp_if rsp();
    smt_cfg_if cfg();

    sorted_multimap_table_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .cfg  (cfg)
    );

    // operations waiting to go out, and results still owed by the block
    table_op_t     pending_ops[$];
    table_result_t expected_results[$];

    // shadow table, updated as each transaction is accepted
    logic signed [KEY_W-1:0]   tbl_key[TABLE_DEPTH];
    logic signed [VALUE_W-1:0] tbl_val[TABLE_DEPTH];
    int                        tbl_count = 0;
    logic                      order_desc = 1'b0;

    // pairs the stimulus believes are stored, used to aim searches and removes
    logic signed [KEY_W-1:0]   live_keys[$];
    logic signed [VALUE_W-1:0] live_vals[$];

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_trigger = 1'b0;
    logic rsp_hold = 1'b0;
    int   mismatch_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // append one result to the list of results owed by the block
    function automatic void expect_result(input logic [STATUS_W-1:0] status,
                                          input logic signed [VALUE_W-1:0] found,
                                          input logic fin,
                                          input int total);
        table_result_t r;
        r.status      = status;
        r.found_value = found;
        r.last        = fin;
        r.entry_total = TOTAL_W'(total);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // true while a stored key may stay ahead of the operand key in the walk
    function automatic logic walk_on(input logic signed [KEY_W-1:0] stored,
                                     input logic signed [KEY_W-1:0] key);
        return order_desc ? (stored >= key) : (stored <= key);
    endfunction

    // apply one accepted operation to the shadow table and queue its results
    task automatic apply_table_op(input logic [KIND_W-1:0] kind,
                                  input logic signed [KEY_W-1:0] key,
                                  input logic signed [VALUE_W-1:0] value);
        int slot;
        int hits;
        int j;
        logic done;
        slot = 0;
        hits = 0;
        done = 1'b0;
        case (kind)
            smt_pkg::KIND_INSERT:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    expect_result(smt_pkg::ST_FULL, '0, 1'b1, tbl_count);
                else
                begin
                    while (slot < tbl_count && walk_on(tbl_key[slot], key))
                        slot++;
                    for (j = tbl_count; j > slot; j--)
                    begin
                        tbl_key[j] = tbl_key[j-1];
                        tbl_val[j] = tbl_val[j-1];
                    end
                    tbl_key[slot] = key;
                    tbl_val[slot] = value;
                    tbl_count++;
                    expect_result(smt_pkg::ST_OK, '0, 1'b1, tbl_count);
                end
            end
            smt_pkg::KIND_SEARCH:
            begin
                for (slot = 0; slot < tbl_count && walk_on(tbl_key[slot], key); slot++)
                begin
                    if (tbl_key[slot] == key)
                    begin
                        expect_result(smt_pkg::ST_OK, tbl_val[slot], 1'b0, tbl_count);
                        hits++;
                    end
                end
                if (hits == 0)
                    expect_result(smt_pkg::ST_MISS, '0, 1'b1, tbl_count);
                else
                    expected_results[expected_results.size()-1].last = 1'b1;
            end
            smt_pkg::KIND_REMOVE:
            begin
                for (slot = 0; !done && slot < tbl_count && walk_on(tbl_key[slot], key);
                     slot++)
                begin
                    if (tbl_key[slot] == key && tbl_val[slot] == value)
                    begin
                        for (j = slot; j + 1 < tbl_count; j++)
                        begin
                            tbl_key[j] = tbl_key[j+1];
                            tbl_val[j] = tbl_val[j+1];
                        end
                        tbl_count--;
                        done = 1'b1;
                    end
                end
                expect_result(done ? smt_pkg::ST_OK : smt_pkg::ST_MISS, '0, 1'b1, tbl_count);
            end
            default:
                expect_result(smt_pkg::ST_MISS, '0, 1'b1, tbl_count);
        endcase
    endtask

    // request driver
    always @(posedge clk)
    begin
        table_op_t next_op;
        if (rst_n && req.valid && req.ready)
            apply_table_op(req.kind, req.key, req.value);
        if (!req.valid || req.ready)
        begin
            if (rst_n && pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_op = pending_ops.pop_front();
                req.valid <= 1'b1;
                req.kind  <= next_op.kind;
                req.key   <= next_op.key;
                req.value <= next_op.value;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // response monitor and checker
    always @(posedge clk)
    begin
        table_result_t seen;
        table_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            seen = '{rsp.status, rsp.found_value, rsp.last, rsp.entry_total};
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b total=%0d",
                                          seen.status, seen.found_value, seen.last,
                                          seen.entry_total));
            else
            begin
                want = expected_results.pop_front();
                if (seen !== want)
                    report_mismatch($sformatf(
                        "status %0d/%0d value %0d/%0d last %0b/%0b total %0d/%0d (exp/got)",
                        want.status, seen.status, want.found_value, seen.found_value,
                        want.last, seen.last, want.entry_total, seen.entry_total));
            end
        end
        rsp.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off so the table backs up into the request channel
    initial
    begin
        wait (hold_trigger);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // run limit
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return KEY_W'($urandom_range(12)) - KEY_W'(6);
        if (r < 70)
        begin
            case ($urandom_range(3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 85 && live_keys.size() != 0)
            return live_keys[$urandom_range(live_keys.size()-1)];
        return $urandom;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 60)
            return VALUE_W'($urandom_range(7));
        return $urandom;
    endfunction

    // queue one operation and keep the stimulus view of the table in step
    task automatic queue_op(input logic [KIND_W-1:0] kind,
                            input logic signed [KEY_W-1:0] key,
                            input logic signed [VALUE_W-1:0] value);
        int i;
        table_op_t op;
        op.kind  = kind;
        op.key   = key;
        op.value = value;
        pending_ops.insert(pending_ops.size(), op);
        if (kind == smt_pkg::KIND_INSERT && live_keys.size() < TABLE_DEPTH)
        begin
            live_keys.insert(live_keys.size(), key);
            live_vals.insert(live_vals.size(), value);
        end
        else if (kind == smt_pkg::KIND_REMOVE)
        begin
            for (i = 0; i < live_keys.size(); i++)
            begin
                if (live_keys[i] == key && live_vals[i] == value)
                begin
                    live_keys.delete(i);
                    live_vals.delete(i);
                    break;
                end
            end
        end
    endtask

    // random mix; removes mostly target pairs that are believed stored
    task automatic queue_random(input int count, input int insert_pct);
        int r;
        int idx;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 3)
                queue_op(KIND_SPARE, $urandom, $urandom);
            else if (r < 3 + insert_pct)
                queue_op(smt_pkg::KIND_INSERT, pick_key(), pick_value());
            else if (r < 3 + insert_pct + (97 - insert_pct) / 2)
                queue_op(smt_pkg::KIND_SEARCH, pick_key(), $urandom);
            else if (live_keys.size() != 0 && $urandom_range(99) < 70)
            begin
                idx = $urandom_range(live_keys.size()-1);
                queue_op(smt_pkg::KIND_REMOVE, live_keys[idx], live_vals[idx]);
            end
            else
                queue_op(smt_pkg::KIND_REMOVE, pick_key(), pick_value());
        end
    endtask

    // write the order register while the table is idle
    task automatic write_order(input logic desc);
        @(posedge clk);
        cfg.valid            <= 1'b1;
        cfg.order_descending <= desc;
        do @(posedge clk); while (!cfg.ready);
        order_desc = desc;
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_ops.size() != 0 || req.valid || expected_results.size() != 0);
    endtask

    // stimulus sequence
    initial
    begin
        rst_n                = 1'b0;
        req.valid            = 1'b0;
        req.kind             = smt_pkg::KIND_INSERT;
        req.key              = '0;
        req.value            = '0;
        rsp.ready            = 1'b0;
        cfg.valid            = 1'b0;
        cfg.order_descending = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicate keys, partial matches
        write_order(1'b0);
        queue_op(smt_pkg::KIND_SEARCH, '0, '0);
        queue_op(smt_pkg::KIND_REMOVE, '0, '0);
        queue_op(KIND_SPARE, KEY_MAX, KEY_MIN);
        queue_op(smt_pkg::KIND_INSERT, KEY_MAX, 1);
        queue_op(smt_pkg::KIND_INSERT, KEY_MIN, 2);
        queue_op(smt_pkg::KIND_INSERT, '0, 3);
        queue_op(smt_pkg::KIND_INSERT, '1, 4);
        queue_op(smt_pkg::KIND_INSERT, 5, 10);
        queue_op(smt_pkg::KIND_INSERT, 5, 11);
        queue_op(smt_pkg::KIND_INSERT, 5, 12);
        queue_op(smt_pkg::KIND_SEARCH, 5, '1);
        queue_op(smt_pkg::KIND_SEARCH, KEY_MIN, '0);
        queue_op(smt_pkg::KIND_SEARCH, KEY_MAX, '0);
        queue_op(smt_pkg::KIND_REMOVE, 5, 99);
        queue_op(smt_pkg::KIND_REMOVE, 5, 11);
        queue_op(smt_pkg::KIND_SEARCH, 5, '0);
        queue_op(smt_pkg::KIND_SEARCH, 6, '0);
        queue_op(smt_pkg::KIND_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
        wait_drained();

        // order flipped with pairs stored, no re-sort
        write_order(1'b1);
        queue_op(smt_pkg::KIND_SEARCH, 5, '0);
        queue_op(smt_pkg::KIND_INSERT, 3, 7);
        queue_op(smt_pkg::KIND_REMOVE, KEY_MIN, 2);
        queue_op(smt_pkg::KIND_SEARCH, KEY_MAX, '0);
        wait_drained();

        // sender idles
        write_order(1'b0);
        send_idle_pct = 66;
        stall_pct     = 0;
        queue_random(45, 50);
        wait_drained();

        // receiver stalls, with one long hold-off
        write_order(1'b1);
        send_idle_pct = 0;
        stall_pct     = 66;
        hold_trigger  = 1'b1;
        queue_random(45, 50);
        wait_drained();

        // both idle a little, insert heavy to reach a full table
        write_order(1'b0);
        send_idle_pct = 9;
        stall_pct     = 9;
        queue_random(75, 90);
        wait_drained();

        // back to back, mostly searches and removes
        write_order(1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_random(35, 30);
        wait_drained();

        repeat (100) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
